@@ sv/lac_pkg.sv @@
// Shared constants, types and the brightness table of the LED additive compositor.
`timescale 1ns / 1ps

package lac_pkg;

  // Geometry of the pixel store and the breathing table
  localparam int PIXEL_COUNT = 128;
  localparam int SINE_STEPS  = 1024;

  localparam int CH_W    = 8;
  localparam int PIX_W   = 3 * CH_W;
  localparam int IDX_W   = (PIXEL_COUNT > 1) ? $clog2(PIXEL_COUNT) : 1;
  localparam int TIME_W  = 32;
  localparam int PER_W   = 16;
  localparam int K_W     = $clog2(SINE_STEPS);
  localparam int ROM_DEPTH = SINE_STEPS / 2 + 1;
  localparam int M_W     = $clog2(ROM_DEPTH);
  localparam int BR_W    = 16;

  // Divider sizing: one quotient bit per cycle
  localparam int DIV_STEPS = TIME_W;
  localparam int DIV_CNT_W = $clog2(DIV_STEPS);

  // Configuration port
  localparam int CFG_IDX_W  = 4;
  localparam int CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] CFG_STATION_BLUE = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_NORTH_RED    = CFG_IDX_W'(1);
  localparam logic [CFG_IDX_W-1:0] CFG_SOUTH_GREEN  = CFG_IDX_W'(2);
  localparam logic [CFG_IDX_W-1:0] CFG_PERIOD_MS    = CFG_IDX_W'(3);

  localparam logic [CH_W-1:0]  RST_STATION_BLUE = 8'd255;
  localparam logic [CH_W-1:0]  RST_NORTH_RED    = 8'd255;
  localparam logic [CH_W-1:0]  RST_SOUTH_GREEN  = 8'd255;
  localparam logic [PER_W-1:0] RST_PERIOD_MS    = 16'd2000;

  // Operation codes; codes above FN_READ behave as a read
  typedef enum logic [2:0] {
    FN_CLEAR   = 3'd0,
    FN_STATION = 3'd1,
    FN_TRAIN   = 3'd2,
    FN_FILL    = 3'd3,
    FN_READ    = 3'd4
  } func_t;

  // Divider request and response
  typedef struct packed {
    logic              start;
    logic [TIME_W-1:0] dividend;
    logic [PER_W-1:0]  divisor;
  } div_req_t;

  typedef struct packed {
    logic              done;
    logic [TIME_W-1:0] quotient;
    logic [PER_W-1:0]  remainder;
  } div_rsp_t;

  // Brightness table, Q1.15, indexed by the folded phase step
  localparam longint PI_Q30  = 64'd3373259426;
  localparam longint ONE_Q30 = 64'd1073741824;
  localparam longint TAYLOR_DEN [7] = '{2, 12, 30, 56, 90, 132, 182};

  typedef logic [ROM_DEPTH-1:0][BR_W-1:0] bright_rom_t;

  function automatic bright_rom_t build_bright_rom();
    bright_rom_t rom;
    longint ang;
    longint x;
    longint x2;
    longint term;
    longint s;
    longint c;
    longint om;
    longint num;
    rom = '0;
    for (int m = 0; m < ROM_DEPTH; m++) begin
      ang = (2 * PI_Q30 * longint'(m)) / SINE_STEPS;
      x   = (ang > PI_Q30 / 2) ? (PI_Q30 - ang) : ang;
      // Taylor series of cos on the first quadrant, each term truncated
      x2   = (x * x) >>> 30;
      term = ONE_Q30;
      s    = ONE_Q30;
      for (int n = 0; n < 7; n++) begin
        term = ((term * x2) >>> 30) / TAYLOR_DEN[n];
        if (n % 2 == 0) s = s - term;
        else            s = s + term;
      end
      c  = (ang > PI_Q30 / 2) ? -s : s;
      om = ONE_Q30 - c;
      if (om < 0) om = 0;
      if (om > 2 * ONE_Q30) om = 2 * ONE_Q30;
      num = 2 * ONE_Q30 + 19 * om + 20 * 32768;
      rom[m] = BR_W'(num / (40 * 32768));
    end
    return rom;
  endfunction

  localparam bright_rom_t BRIGHT_ROM = build_bright_rom();

endpackage

@@ sv/led_additive_compositor.sv @@
// Top level of the LED additive compositor: pixel store, operation sequencer, outputs.
`timescale 1ns / 1ps

// Holds PIXEL_COUNT RGB pixels in a RAM with one valid bit per pixel and a base colour
// register, so clear and fill complete in one step without sweeping the RAM. One item
// is worked at a time and yields exactly one result; the result sits in an output
// register, so the next item is taken while it waits. Clear, fill, read, station add
// and inactive or badly indexed train add read the RAM, then modify and write back.
// An active train add at a good index makes two passes through the shared bit-serial
// divider (time modulo period, then the phase step), then a table lookup, a scaling
// multiply, the write back and the return to idle. A result still waiting in the
// output register holds the write back until it is taken. Configuration writes are
// always taken (cfg_ready is tied high) and belong between items, while nothing is
// in flight.

module led_additive_compositor import lac_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,

  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [2:0]            in_func,
  input  logic [7:0]            in_led_index,
  input  logic                  in_active,
  input  logic                  in_northbound,
  input  logic [TIME_W-1:0]     in_time_ms,
  input  logic [CH_W-1:0]       in_fill_red,
  input  logic [CH_W-1:0]       in_fill_green,
  input  logic [CH_W-1:0]       in_fill_blue,

  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [CH_W-1:0]       out_pixel_red,
  output logic [CH_W-1:0]       out_pixel_green,
  output logic [CH_W-1:0]       out_pixel_blue,
  output logic                  out_was_written,
  output logic                  out_index_bad,

  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_DIV_T,
    S_DIV_K,
    S_ROM,
    S_MUL,
    S_APPLY
  } state_t;

  state_t state_r, state_nxt;

  // Configuration registers
  logic [CH_W-1:0]  station_blue_r;
  logic [CH_W-1:0]  north_red_r;
  logic [CH_W-1:0]  south_green_r;
  logic [PER_W-1:0] period_r;

  // Store bookkeeping
  logic [PIXEL_COUNT-1:0] valid_r;
  logic [PIX_W-1:0]       base_r;

  // Item held while it is worked
  func_t            func_r;
  logic [IDX_W-1:0] idx_r;
  logic             good_r;
  logic             active_r;
  logic             north_r;
  logic [PIX_W-1:0] fill_r;
  logic [K_W-1:0]   k_r;
  logic [BR_W-1:0]  bright_r;
  logic [CH_W-1:0]  scaled_r;

  // Output register
  logic             out_valid_r;
  logic [PIX_W-1:0] out_pix_r;
  logic             out_wrote_r;
  logic             out_bad_r;

  logic             in_fire;
  logic             in_good;
  logic [PER_W-1:0] per;
  div_req_t         div_req;
  div_rsp_t         div_rsp;

  logic             ram_we;
  logic [PIX_W-1:0] ram_rdata;

  logic [K_W:0]     k_ext;
  logic [K_W:0]     k_mirror;
  logic [K_W:0]     m_full;
  logic [CH_W-1:0]  train_color;
  logic [23:0]      scale_prod;

  logic [PIX_W-1:0] cur_pix;
  logic [PIX_W-1:0] new_pix;
  logic             wr_px;
  logic             wr_all;
  logic             wrote;
  logic             go;

  function automatic logic [CH_W-1:0] sat_add(input logic [CH_W-1:0] a,
                                              input logic [CH_W-1:0] b);
    logic [CH_W:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[CH_W] ? {CH_W{1'b1}} : s[CH_W-1:0];
  endfunction

  assign in_ready  = (state_r == S_IDLE);
  assign in_fire   = in_valid && in_ready;
  assign in_good   = ({1'b0, in_led_index} < 9'(PIXEL_COUNT));
  assign cfg_ready = 1'b1;

  // A zero period counts as one
  assign per = (period_r == '0) ? PER_W'(1) : period_r;

  // Divider: time mod period first, then remainder * steps / period
  always_comb begin
    div_req.start    = 1'b0;
    div_req.dividend = in_time_ms;
    div_req.divisor  = per;
    if (state_r == S_DIV_T) begin
      div_req.start    = div_rsp.done;
      div_req.dividend = TIME_W'(div_rsp.remainder) * TIME_W'(SINE_STEPS);
    end else if (in_fire && (func_t'(in_func) == FN_TRAIN) && in_good && in_active) begin
      div_req.start = 1'b1;
    end
  end

  lac_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  // Pixel RAM: read at acceptance, written back on completion
  lac_ram #(
    .WIDTH (PIX_W),
    .DEPTH (PIXEL_COUNT)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (idx_r),
    .wdata (new_pix),
    .re    (in_fire),
    .raddr (in_led_index[IDX_W-1:0]),
    .rdata (ram_rdata)
  );

  // Fold the phase step onto the half table, pick the train colour
  always_comb begin
    k_ext       = {1'b0, k_r};
    k_mirror    = (K_W + 1)'(SINE_STEPS) - k_ext;
    m_full      = (k_ext <= k_mirror) ? k_ext : k_mirror;
    train_color = north_r ? north_red_r : south_green_r;
    scale_prod  = 24'(train_color) * 24'(bright_r);
  end

  // Modify step: pixel as stored, then the operation on it
  always_comb begin
    cur_pix = valid_r[idx_r] ? ram_rdata : base_r;
    new_pix = cur_pix;
    wr_px   = 1'b0;
    wr_all  = 1'b0;
    wrote   = 1'b0;
    unique case (func_r)
      FN_CLEAR: begin
        new_pix = '0;
        wr_all  = 1'b1;
        wrote   = 1'b1;
      end
      FN_FILL: begin
        new_pix = fill_r;
        wr_all  = 1'b1;
        wrote   = 1'b1;
      end
      FN_STATION: begin
        if (good_r) begin
          new_pix[CH_W-1:0] = sat_add(cur_pix[CH_W-1:0], station_blue_r);
          wr_px = 1'b1;
          wrote = 1'b1;
        end
      end
      FN_TRAIN: begin
        if (good_r && active_r) begin
          if (north_r) begin
            new_pix[PIX_W-1:2*CH_W] = sat_add(cur_pix[PIX_W-1:2*CH_W], scaled_r);
          end else begin
            new_pix[2*CH_W-1:CH_W] = sat_add(cur_pix[2*CH_W-1:CH_W], scaled_r);
          end
          wr_px = 1'b1;
          wrote = 1'b1;
        end
      end
      default: ;
    endcase
  end

  // Finish only once the output register is free
  assign go     = (state_r == S_APPLY) && (!out_valid_r || out_ready);
  assign ram_we = go && wr_px;

  // Sequencer
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          state_nxt = div_req.start ? S_DIV_T : S_APPLY;
        end
      end
      S_DIV_T: if (div_rsp.done) state_nxt = S_DIV_K;
      S_DIV_K: if (div_rsp.done) state_nxt = S_ROM;
      S_ROM:   state_nxt = S_MUL;
      S_MUL:   state_nxt = S_APPLY;
      S_APPLY: if (go) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  // State, configuration, store bookkeeping and registered outputs
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r        <= S_IDLE;
      out_valid_r    <= 1'b0;
      valid_r        <= '0;
      base_r         <= '0;
      station_blue_r <= RST_STATION_BLUE;
      north_red_r    <= RST_NORTH_RED;
      south_green_r  <= RST_SOUTH_GREEN;
      period_r       <= RST_PERIOD_MS;
    end else begin
      state_r <= state_nxt;

      if (cfg_valid) begin
        unique case (cfg_index)
          CFG_STATION_BLUE: station_blue_r <= cfg_data[CH_W-1:0];
          CFG_NORTH_RED:    north_red_r    <= cfg_data[CH_W-1:0];
          CFG_SOUTH_GREEN:  south_green_r  <= cfg_data[CH_W-1:0];
          CFG_PERIOD_MS:    period_r       <= cfg_data[PER_W-1:0];
          default: ;
        endcase
      end

      if (go && wr_all) begin
        valid_r <= '0;
        base_r  <= new_pix;
      end else if (ram_we) begin
        valid_r[idx_r] <= 1'b1;
      end

      if (go) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end

      if (go) begin
        out_pix_r   <= good_r ? new_pix : '0;
        out_wrote_r <= wrote;
        out_bad_r   <= !good_r;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (in_fire) begin
      func_r   <= func_t'(in_func);
      idx_r    <= in_led_index[IDX_W-1:0];
      good_r   <= in_good;
      active_r <= in_active;
      north_r  <= in_northbound;
      fill_r   <= {in_fill_red, in_fill_green, in_fill_blue};
    end
    if ((state_r == S_DIV_K) && div_rsp.done) begin
      k_r <= div_rsp.quotient[K_W-1:0];
    end
    if (state_r == S_ROM) begin
      bright_r <= BRIGHT_ROM[m_full[M_W-1:0]];
    end
    if (state_r == S_MUL) begin
      scaled_r <= scale_prod[15+CH_W-1:15];
    end
  end

  assign out_valid       = out_valid_r;
  assign out_pixel_red   = out_pix_r[PIX_W-1:2*CH_W];
  assign out_pixel_green = out_pix_r[2*CH_W-1:CH_W];
  assign out_pixel_blue  = out_pix_r[CH_W-1:0];
  assign out_was_written = out_wrote_r;
  assign out_index_bad   = out_bad_r;

endmodule

@@ sv/lac_ram.sv @@
// Generic single-port-write, single-port-read RAM with registered read data.
`timescale 1ns / 1ps

module lac_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 128
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic                                   re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // Write port and registered read port; read data holds between reads
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

@@ sv/lac_div.sv @@
// Restoring bit-serial divider: 32-bit dividend by 16-bit divisor.
`timescale 1ns / 1ps

module lac_div import lac_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  div_req_t req,
  output div_rsp_t rsp
);

  logic                 busy_r;
  logic                 done_r;
  logic [DIV_CNT_W-1:0] cnt_r;
  logic [TIME_W-1:0]    dvd_r;
  logic [PER_W-1:0]     rem_r;
  logic [PER_W-1:0]     dvs_r;

  logic [PER_W:0]       rem_sh;
  logic                 fits;
  logic [PER_W-1:0]     rem_nxt;
  logic [TIME_W-1:0]    dvd_nxt;

  // One quotient bit: shift in the next dividend bit, subtract if it fits
  always_comb begin
    rem_sh  = {rem_r, dvd_r[TIME_W-1]};
    fits    = (rem_sh >= {1'b0, dvs_r});
    rem_nxt = fits ? PER_W'(rem_sh - {1'b0, dvs_r}) : rem_sh[PER_W-1:0];
    dvd_nxt = {dvd_r[TIME_W-2:0], fits};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
        dvd_r  <= req.dividend;
        rem_r  <= '0;
        dvs_r  <= req.divisor;
      end else if (busy_r) begin
        dvd_r <= dvd_nxt;
        rem_r <= rem_nxt;
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == DIV_CNT_W'(DIV_STEPS - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // Quotient ends up in the dividend shift register
  assign rsp.done      = done_r;
  assign rsp.quotient  = dvd_r;
  assign rsp.remainder = rem_r;

endmodule

@@ tb/sv/led_additive_compositor_tb.sv @@
// Self-checking testbench for the LED additive compositor: shadow pixel store and checks.
`timescale 1ns / 1ps

module led_additive_compositor_tb;
  import lac_pkg::*;

  // Fixed-point constants of the breathing curve (Q30)
  localparam longint HALF_TURN_Q30 = 64'd3373259426;
  localparam longint UNIT_Q30      = 64'd1073741824;
  localparam int     CYCLE_LIMIT   = 400000;
  localparam int     RANDOM_PHASES = 5;
  localparam int     OPS_PER_PHASE = 80;
  localparam int     DRAIN_CYCLES  = 80;

  typedef struct packed {
    logic [2:0]        func;
    logic [7:0]        idx;
    logic              active;
    logic              north;
    logic [TIME_W-1:0] t;
    logic [CH_W-1:0]   fr;
    logic [CH_W-1:0]   fg;
    logic [CH_W-1:0]   fb;
  } strip_op_t;

  typedef struct packed {
    logic [CH_W-1:0] red;
    logic [CH_W-1:0] green;
    logic [CH_W-1:0] blue;
    logic            was_written;
    logic            index_bad;
  } pixel_result_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic                  in_valid = 1'b0;
  logic                  in_ready;
  logic [2:0]            in_func = '0;
  logic [7:0]            in_led_index = '0;
  logic                  in_active = 1'b0;
  logic                  in_northbound = 1'b0;
  logic [TIME_W-1:0]     in_time_ms = '0;
  logic [CH_W-1:0]       in_fill_red = '0;
  logic [CH_W-1:0]       in_fill_green = '0;
  logic [CH_W-1:0]       in_fill_blue = '0;

  logic                  out_valid;
  logic                  out_ready = 1'b0;
  logic [CH_W-1:0]       out_pixel_red;
  logic [CH_W-1:0]       out_pixel_green;
  logic [CH_W-1:0]       out_pixel_blue;
  logic                  out_was_written;
  logic                  out_index_bad;

  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  // Shadow of the pixel store and the registers
  logic [CH_W-1:0]  shadow_red   [PIXEL_COUNT];
  logic [CH_W-1:0]  shadow_green [PIXEL_COUNT];
  logic [CH_W-1:0]  shadow_blue  [PIXEL_COUNT];
  logic [CH_W-1:0]  cur_station_blue = RST_STATION_BLUE;
  logic [CH_W-1:0]  cur_north_red    = RST_NORTH_RED;
  logic [CH_W-1:0]  cur_south_green  = RST_SOUTH_GREEN;
  logic [PER_W-1:0] cur_period_ms    = RST_PERIOD_MS;

  strip_op_t     pending_ops[$];
  pixel_result_t expected_pixels[$];
  strip_op_t     driven_op;

  int  send_gap = 0;
  int  hold_gap = 0;
  bit  steady_flow = 1'b0;
  int  items_sent = 0;
  int  results_seen = 0;
  int  cfg_writes = 0;
  int  error_count = 0;
  int  mismatch_count = 0;
  int  cycle_count = 0;

  led_additive_compositor u_top (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_func         (in_func),
    .in_led_index    (in_led_index),
    .in_active       (in_active),
    .in_northbound   (in_northbound),
    .in_time_ms      (in_time_ms),
    .in_fill_red     (in_fill_red),
    .in_fill_green   (in_fill_green),
    .in_fill_blue    (in_fill_blue),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_pixel_red   (out_pixel_red),
    .out_pixel_green (out_pixel_green),
    .out_pixel_blue  (out_pixel_blue),
    .out_was_written (out_was_written),
    .out_index_bad   (out_index_bad),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data)
  );

  always #5 clk = ~clk;

  // Truncated Taylor cosine on the first quadrant, Q30 in and out
  function automatic longint cos_first_quadrant(longint x);
    longint x2;
    longint term;
    longint csum;
    x2   = (x * x) >> 30;
    term = UNIT_Q30;
    csum = UNIT_Q30;
    for (int n = 1; n <= 7; n++) begin
      term = ((term * x2) >> 30) / ((2 * n - 1) * (2 * n));
      if (n % 2 == 1) csum = csum - term;
      else            csum = csum + term;
    end
    return csum;
  endfunction

  // Breathing brightness in Q1.15 for one phase step
  function automatic longint breath_level(longint step);
    longint fold;
    longint ang;
    longint c;
    longint omc;
    longint num;
    fold = (step <= SINE_STEPS - step) ? step : SINE_STEPS - step;
    ang  = (2 * HALF_TURN_Q30 * fold) / SINE_STEPS;
    if (ang > HALF_TURN_Q30 / 2) c = -cos_first_quadrant(HALF_TURN_Q30 - ang);
    else                         c = cos_first_quadrant(ang);
    omc = UNIT_Q30 - c;
    if (omc < 0) omc = 0;
    if (omc > 2 * UNIT_Q30) omc = 2 * UNIT_Q30;
    num = 2 * UNIT_Q30 + 19 * omc + 20 * 32768;
    return num / (40 * 32768);
  endfunction

  function automatic logic [CH_W-1:0] sat_channel(logic [CH_W-1:0] a, longint b);
    longint s;
    s = longint'(a) + b;
    return (s > 255) ? 8'hFF : CH_W'(s);
  endfunction

  // Applies one operation to the shadow store and returns the pixel it reports
  function automatic pixel_result_t apply_strip_op(strip_op_t op);
    pixel_result_t res;
    logic          good;
    longint        per;
    longint        step;
    longint        level;
    good = (op.idx < PIXEL_COUNT);
    res  = '0;
    case (op.func)
      FN_CLEAR: begin
        for (int p = 0; p < PIXEL_COUNT; p++) begin
          shadow_red[p] = '0; shadow_green[p] = '0; shadow_blue[p] = '0;
        end
        res.was_written = 1'b1;
      end
      FN_FILL: begin
        for (int p = 0; p < PIXEL_COUNT; p++) begin
          shadow_red[p] = op.fr; shadow_green[p] = op.fg; shadow_blue[p] = op.fb;
        end
        res.was_written = 1'b1;
      end
      FN_STATION: begin
        if (good) begin
          shadow_blue[op.idx] = sat_channel(shadow_blue[op.idx], cur_station_blue);
          res.was_written = 1'b1;
        end
      end
      FN_TRAIN: begin
        if (good && op.active) begin
          // a zero period behaves as one, so the phase is always zero
          per   = (cur_period_ms == 0) ? 1 : longint'(cur_period_ms);
          step  = ((longint'(op.t) % per) * SINE_STEPS) / per;
          level = breath_level(step);
          if (op.north)
            shadow_red[op.idx] = sat_channel(shadow_red[op.idx],
                                             (longint'(cur_north_red) * level) >> 15);
          else
            shadow_green[op.idx] = sat_channel(shadow_green[op.idx],
                                               (longint'(cur_south_green) * level) >> 15);
          res.was_written = 1'b1;
        end
      end
      default: ;  // read, and unknown codes behave as a read
    endcase
    if (good) begin
      res.red   = shadow_red[op.idx];
      res.green = shadow_green[op.idx];
      res.blue  = shadow_blue[op.idx];
    end
    res.index_bad = !good;
    return res;
  endfunction

  // Mostly short gaps, now and then a long one
  function automatic int draw_gap();
    int sel;
    sel = $urandom_range(0, 99);
    if (steady_flow || sel < 60) return 0;
    if (sel < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function automatic strip_op_t make_op(logic [2:0] func, logic [7:0] idx, logic active,
                                        logic north, logic [TIME_W-1:0] t,
                                        logic [CH_W-1:0] fr, logic [CH_W-1:0] fg,
                                        logic [CH_W-1:0] fb);
    strip_op_t op;
    op = '{func, idx, active, north, t, fr, fg, fb};
    return op;
  endfunction

  // Random operation; a small set of hot pixels makes saturation likely
  function automatic strip_op_t random_op();
    strip_op_t op;
    int        sel;
    sel = $urandom_range(0, 99);
    if (sel < 38)      op.func = FN_TRAIN;
    else if (sel < 58) op.func = FN_STATION;
    else if (sel < 78) op.func = FN_READ;
    else if (sel < 86) op.func = FN_FILL;
    else if (sel < 91) op.func = FN_CLEAR;
    else               op.func = 3'($urandom_range(5, 7));
    sel = $urandom_range(0, 99);
    if (sel < 40)      op.idx = 8'($urandom_range(0, 7));
    else if (sel < 82) op.idx = 8'($urandom_range(0, PIXEL_COUNT - 1));
    else               op.idx = 8'($urandom_range(PIXEL_COUNT, 255));
    op.active = ($urandom_range(0, 9) != 0);
    op.north  = 1'($urandom_range(0, 1));
    op.t      = ($urandom_range(0, 3) == 0) ? TIME_W'($urandom_range(0, 4000)) : $urandom();
    op.fr     = 8'($urandom());
    op.fg     = 8'($urandom());
    op.fb     = 8'($urandom());
    return op;
  endfunction

  // Input driver: presents queued operations with random gaps
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      send_gap = 0;
    end else begin
      if (in_valid && in_ready) begin
        expected_pixels.push_back(apply_strip_op(driven_op));
        items_sent++;
      end
      if (!in_valid || in_ready) begin
        if (send_gap > 0) begin
          send_gap--;
          in_valid <= 1'b0;
        end else if (pending_ops.size() > 0) begin
          driven_op = pending_ops.pop_front();
          in_valid      <= 1'b1;
          in_func       <= driven_op.func;
          in_led_index  <= driven_op.idx;
          in_active     <= driven_op.active;
          in_northbound <= driven_op.north;
          in_time_ms    <= driven_op.t;
          in_fill_red   <= driven_op.fr;
          in_fill_green <= driven_op.fg;
          in_fill_blue  <= driven_op.fb;
          send_gap = draw_gap();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Result monitor: compares each transaction with the oldest expected pixel
  always @(posedge clk) begin
    pixel_result_t got;
    pixel_result_t want;
    if (!rst_n) begin
      out_ready <= 1'b0;
      hold_gap = 0;
    end else begin
      if (out_valid && out_ready) begin
        results_seen++;
        got = '{out_pixel_red, out_pixel_green, out_pixel_blue,
                out_was_written, out_index_bad};
        if (expected_pixels.size() == 0) begin
          error_count++;
          $display("unexpected result: r=%0d g=%0d b=%0d wr=%0b bad=%0b",
                   got.red, got.green, got.blue, got.was_written, got.index_bad);
        end else begin
          want = expected_pixels.pop_front();
          if (got !== want) begin
            error_count++;
            mismatch_count++;
            if (mismatch_count <= 10)
              $display("mismatch on result %0d: expected r=%0d g=%0d b=%0d wr=%0b bad=%0b, got r=%0d g=%0d b=%0d wr=%0b bad=%0b",
                       results_seen, want.red, want.green, want.blue, want.was_written,
                       want.index_bad, got.red, got.green, got.blue, got.was_written,
                       got.index_bad);
          end
        end
      end
      if (hold_gap > 0) begin
        hold_gap--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
        hold_gap = draw_gap();
      end
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding",
               cycle_count, expected_pixels.size());
      $display("led_additive_compositor_tb: FAIL");
      $finish;
    end
  end

  // Register write; the shadow copy follows at the accepting edge
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    cfg_writes++;
    case (idx)
      CFG_STATION_BLUE: cur_station_blue = data[CH_W-1:0];
      CFG_NORTH_RED:    cur_north_red    = data[CH_W-1:0];
      CFG_SOUTH_GREEN:  cur_south_green  = data[CH_W-1:0];
      CFG_PERIOD_MS:    cur_period_ms    = data[PER_W-1:0];
      default: ;
    endcase
  endtask

  // Colour registers get random upper bits, which must be dropped
  task automatic write_colours(input logic [CH_W-1:0] blue, input logic [CH_W-1:0] red,
                               input logic [CH_W-1:0] green);
    write_reg(CFG_STATION_BLUE, {8'($urandom()), blue});
    write_reg(CFG_NORTH_RED,    {8'($urandom()), red});
    write_reg(CFG_SOUTH_GREEN,  {8'($urandom()), green});
  endtask

  // Wait until every queued transaction has been answered
  task automatic wait_drained();
    do @(negedge clk);
    while (pending_ops.size() != 0 || in_valid || expected_pixels.size() != 0);
    repeat (4) @(negedge clk);
  endtask

  // Stimulus sequence
  initial begin
    for (int p = 0; p < PIXEL_COUNT; p++) begin
      shadow_red[p] = '0; shadow_green[p] = '0; shadow_blue[p] = '0;
    end
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed part on reset settings: edges of index, saturation, breathing extremes
    pending_ops.push_back(make_op(FN_READ, 8'd0, 1'b0, 1'b0, '0, '0, '0, '0));
    pending_ops.push_back(make_op(FN_READ, 8'd127, 1'b1, 1'b1, '1, '1, '1, '1));
    pending_ops.push_back(make_op(FN_READ, 8'd128, 1'b0, 1'b0, '0, '0, '0, '0));
    pending_ops.push_back(make_op(FN_READ, 8'd255, 1'b0, 1'b0, '0, '0, '0, '0));
    pending_ops.push_back(make_op(FN_STATION, 8'd0, 1'b0, 1'b0, '0, '0, '0, '0));
    pending_ops.push_back(make_op(FN_STATION, 8'd0, 1'b0, 1'b0, '0, '0, '0, '0));
    pending_ops.push_back(make_op(FN_TRAIN, 8'd1, 1'b1, 1'b1, 32'd0, '0, '0, '0));
    pending_ops.push_back(make_op(FN_TRAIN, 8'd1, 1'b1, 1'b1, 32'd1000, '0, '0, '0));
    pending_ops.push_back(make_op(FN_TRAIN, 8'd2, 1'b1, 1'b0, 32'd500, '0, '0, '0));
    pending_ops.push_back(make_op(FN_TRAIN, 8'd2, 1'b1, 1'b0, 32'hFFFF_FFFF, '0, '0, '0));
    pending_ops.push_back(make_op(FN_TRAIN, 8'd2, 1'b0, 1'b1, 32'd1000, '0, '0, '0));
    pending_ops.push_back(make_op(FN_TRAIN, 8'd200, 1'b1, 1'b1, 32'd1000, '0, '0, '0));
    pending_ops.push_back(make_op(FN_STATION, 8'd130, 1'b0, 1'b0, '0, '0, '0, '0));
    pending_ops.push_back(make_op(FN_FILL, 8'd64, 1'b0, 1'b0, '0, 8'hFF, 8'h00, 8'hA5));
    pending_ops.push_back(make_op(FN_READ, 8'd64, 1'b0, 1'b0, '0, '0, '0, '0));
    pending_ops.push_back(make_op(FN_STATION, 8'd64, 1'b0, 1'b0, '0, '0, '0, '0));
    pending_ops.push_back(make_op(FN_TRAIN, 8'd127, 1'b1, 1'b1, 32'd1999, '0, '0, '0));
    pending_ops.push_back(make_op(3'd5, 8'd3, 1'b1, 1'b1, '1, '1, '1, '1));
    pending_ops.push_back(make_op(3'd6, 8'd127, 1'b0, 1'b0, '0, '0, '0, '0));
    pending_ops.push_back(make_op(3'd7, 8'd255, 1'b1, 1'b0, '0, '0, '0, '0));
    pending_ops.push_back(make_op(FN_CLEAR, 8'd10, 1'b0, 1'b0, '0, '1, '1, '1));
    pending_ops.push_back(make_op(FN_READ, 8'd64, 1'b0, 1'b0, '0, '0, '0, '0));
    pending_ops.push_back(make_op(FN_FILL, 8'd255, 1'b0, 1'b0, '0, 8'hFF, 8'hFF, 8'hFF));
    pending_ops.push_back(make_op(FN_TRAIN, 8'd0, 1'b1, 1'b0, 32'd250, '0, '0, '0));
    pending_ops.push_back(make_op(FN_CLEAR, 8'd200, 1'b0, 1'b0, '0, '0, '0, '0));
    wait_drained();

    // Random phases, each on its own register setting
    for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
      steady_flow = 1'b0;
      case (ph)
        0: begin
          write_colours(8'd0, 8'd0, 8'd0);
          write_reg(CFG_PERIOD_MS, 16'd1);
        end
        1: begin
          write_colours(8'hFF, 8'hFF, 8'hFF);
          write_reg(CFG_PERIOD_MS, 16'hFFFF);
          steady_flow = 1'b1;
        end
        2: begin
          write_colours(8'($urandom()), 8'($urandom()), 8'($urandom()));
          write_reg(CFG_PERIOD_MS, 16'($urandom_range(1, 3000)));
        end
        3: begin
          // a zero period and an unused register index
          write_colours(8'($urandom()), 8'($urandom()), 8'($urandom()));
          write_reg(CFG_PERIOD_MS, 16'd0);
          write_reg(CFG_IDX_W'($urandom_range(4, 15)), 16'($urandom()));
        end
        default: begin
          write_colours(8'($urandom()), 8'($urandom()), 8'($urandom()));
          write_reg(CFG_PERIOD_MS, 16'($urandom_range(1, 65535)));
          write_reg(CFG_IDX_W'($urandom_range(4, 15)), 16'($urandom()));
        end
      endcase
      @(negedge clk);
      for (int i = 0; i < OPS_PER_PHASE; i++) pending_ops.push_back(random_op());
      wait_drained();
    end

    steady_flow = 1'b0;
    repeat (DRAIN_CYCLES) @(negedge clk);

    $display("run covered %0d operations, %0d results and %0d register writes over %0d settings",
             items_sent, results_seen, cfg_writes, RANDOM_PHASES + 1);
    $display("%0d mismatching results, %0d results still outstanding",
             mismatch_count, expected_pixels.size());
    if (error_count == 0 && expected_pixels.size() == 0) begin
      $display("led_additive_compositor_tb: PASS");
    end else begin
      $display("led_additive_compositor_tb: FAIL");
    end
    $finish;
  end

endmodule
